/* hdl/dclf_pkg.sv */
// shared types, constants and lookup tables for the command line filter
// no dependencies; used through scoped names by every module of the block except dclf_checker
package dclf_pkg;

	typedef enum logic [2:0] {
		PH_DIGIT = 3'd0,
		PH_SPACE = 3'd1,
		PH_WORD  = 3'd2,
		PH_SCAN  = 3'd3,
		PH_REST  = 3'd4
	} phase_t;

	localparam int NAME_COUNT = 5;
	localparam int HISTORY    = 5;
	localparam int PREFIX_LEN = 17;
	localparam int WLEN_W     = 5;
	localparam int SCNT_W     = 3;

	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_BAR  = 8'h7C;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// shell, pipe, python, guile, make; padded to eight bytes
	localparam logic [7:0] NAME_TAB [NAME_COUNT][8] = '{
		'{8'h73, 8'h68, 8'h65, 8'h6C, 8'h6C, 8'h00, 8'h00, 8'h00},
		'{8'h70, 8'h69, 8'h70, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h70, 8'h79, 8'h74, 8'h68, 8'h6F, 8'h6E, 8'h00, 8'h00},
		'{8'h67, 8'h75, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},
		'{8'h6D, 8'h61, 8'h6B, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{3'd5, 3'd4, 3'd6, 3'd5, 3'd4};

	// -interpreter-exec
	localparam logic [7:0] PREFIX_TAB [PREFIX_LEN] = '{
		8'h2D, 8'h69, 8'h6E, 8'h74, 8'h65, 8'h72, 8'h70, 8'h72, 8'h65,
		8'h74, 8'h65, 8'h72, 8'h2D, 8'h65, 8'h78, 8'h65, 8'h63
	};

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} byte_stage_t;

	typedef struct packed {
		logic push;
		logic blocked;
	} result_t;

endpackage

/* hdl/dclf_in_reg.sv */
// input register stage: holds one accepted byte until the filter engine takes it
// depends on dclf_pkg
module dclf_in_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic                  step,
	output dclf_pkg::byte_stage_t stage_s1
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign stage_s1.valid = valid_s1;
	assign stage_s1.data  = data_s1;
	assign stage_s1.last  = last_s1;

endmodule

/* hdl/dclf_engine.sv */
// per-line filter state and the combinational byte decision
// depends on dclf_pkg
module dclf_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  dclf_pkg::byte_stage_t stage_s1,
	input  logic                  bypass,
	output dclf_pkg::result_t     res
);

	dclf_pkg::phase_t                phase_q, phase_d;
	logic [dclf_pkg::NAME_COUNT-1:0] name_alive_q, name_alive_d;
	logic [dclf_pkg::WLEN_W-1:0]     word_len_q, word_len_d;
	logic                            prefix_alive_q, prefix_alive_d;
	logic [7:0]                      recent_q [dclf_pkg::HISTORY];
	logic [7:0]                      recent_d [dclf_pkg::HISTORY];
	logic [dclf_pkg::SCNT_W-1:0]     scan_cnt_q, scan_cnt_d;
	logic                            hit_q, hit_d;
	logic                            blocked_d;

	always_comb begin
		logic [7:0] b;
		logic       is_blank;
		logic       is_digit;
		logic       is_flag;
		logic       word_go;
		logic       scan_go;
		logic       m;
		int         n;

		b        = stage_s1.data;
		is_blank = (b == dclf_pkg::CH_SP) || (b == dclf_pkg::CH_TAB);
		is_digit = (b >= dclf_pkg::CH_ZERO) && (b <= dclf_pkg::CH_NINE);
		is_flag  = (b == dclf_pkg::CH_BANG) || (b == dclf_pkg::CH_BAR);
		word_go  = 1'b0;
		scan_go  = 1'b0;
		m        = 1'b0;
		n        = 0;

		phase_d        = phase_q;
		name_alive_d   = name_alive_q;
		word_len_d     = word_len_q;
		prefix_alive_d = prefix_alive_q;
		recent_d       = recent_q;
		scan_cnt_d     = scan_cnt_q;
		hit_d          = hit_q;

		if (b != dclf_pkg::CH_NL) begin
			case (phase_q)
				dclf_pkg::PH_DIGIT, dclf_pkg::PH_SPACE: begin
					if (phase_q == dclf_pkg::PH_DIGIT && is_digit) begin
						phase_d = dclf_pkg::PH_DIGIT;
					end else if (is_blank) begin
						phase_d = dclf_pkg::PH_SPACE;
					end else if (is_flag) begin
						hit_d   = 1'b1;
						phase_d = dclf_pkg::PH_REST;
					end else begin
						phase_d = dclf_pkg::PH_WORD;
						word_go = 1'b1;
					end
				end
				dclf_pkg::PH_WORD: word_go = 1'b1;
				dclf_pkg::PH_SCAN: scan_go = 1'b1;
				default: ;
			endcase
		end

		if (word_go) begin
			if (is_blank || b == dclf_pkg::CH_CR) begin
				// word closed by a separator
				if (word_len_q >= 5'd2 && |name_alive_q)
					hit_d = 1'b1;
				phase_d = dclf_pkg::PH_REST;
			end else begin
				for (int d = 0; d < dclf_pkg::NAME_COUNT; d++) begin
					if (word_len_q < {2'b00, dclf_pkg::NAME_LEN[d]} &&
					    b != dclf_pkg::NAME_TAB[d][word_len_q[2:0]])
						name_alive_d[d] = 1'b0;
				end
				if (word_len_q < dclf_pkg::WLEN_W'(dclf_pkg::PREFIX_LEN) &&
				    b != dclf_pkg::PREFIX_TAB[word_len_q])
					prefix_alive_d = 1'b0;
				if (word_len_q != {dclf_pkg::WLEN_W{1'b1}})
					word_len_d = word_len_q + 5'd1;
				if (prefix_alive_d && word_len_d == dclf_pkg::WLEN_W'(dclf_pkg::PREFIX_LEN)) begin
					phase_d    = dclf_pkg::PH_SCAN;
					scan_cnt_d = '0;
					for (int i = 0; i < dclf_pkg::HISTORY; i++)
						recent_d[i] = 8'h00;
				end
			end
		end

		if (scan_go) begin
			if (is_flag)
				hit_d = 1'b1;
			// a name completes when its last byte arrives after the rest in history
			for (int d = 0; d < dclf_pkg::NAME_COUNT; d++) begin
				n = int'(dclf_pkg::NAME_LEN[d]);
				m = (scan_cnt_q >= dclf_pkg::SCNT_W'(n - 1)) &&
				    (b == dclf_pkg::NAME_TAB[d][3'(n - 1)]);
				for (int i = 0; i < dclf_pkg::HISTORY; i++) begin
					if (i < n - 1 && recent_q[i] != dclf_pkg::NAME_TAB[d][3'(n - 2 - i)])
						m = 1'b0;
				end
				if (m)
					hit_d = 1'b1;
			end
			recent_d[0] = b;
			for (int i = 1; i < dclf_pkg::HISTORY; i++)
				recent_d[i] = recent_q[i-1];
			if (scan_cnt_q != {dclf_pkg::SCNT_W{1'b1}})
				scan_cnt_d = scan_cnt_q + 3'd1;
		end

		// end of line: judge an open first word, then restart the line
		if (b == dclf_pkg::CH_NL || stage_s1.last) begin
			if (phase_d == dclf_pkg::PH_WORD && word_len_d >= 5'd2 && |name_alive_d)
				hit_d = 1'b1;
			phase_d        = dclf_pkg::PH_DIGIT;
			name_alive_d   = '1;
			word_len_d     = '0;
			prefix_alive_d = 1'b1;
			scan_cnt_d     = '0;
			for (int i = 0; i < dclf_pkg::HISTORY; i++)
				recent_d[i] = 8'h00;
		end

		blocked_d = hit_d && !bypass;
		if (stage_s1.last)
			hit_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= dclf_pkg::PH_DIGIT;
			name_alive_q   <= '1;
			word_len_q     <= '0;
			prefix_alive_q <= 1'b1;
			scan_cnt_q     <= '0;
			hit_q          <= 1'b0;
			for (int i = 0; i < dclf_pkg::HISTORY; i++)
				recent_q[i] <= 8'h00;
		end else if (step) begin
			phase_q        <= phase_d;
			name_alive_q   <= name_alive_d;
			word_len_q     <= word_len_d;
			prefix_alive_q <= prefix_alive_d;
			scan_cnt_q     <= scan_cnt_d;
			hit_q          <= hit_d;
			recent_q       <= recent_d;
		end
	end

	assign res.push    = step && stage_s1.last;
	assign res.blocked = blocked_d;

endmodule

/* hdl/dclf_out_reg.sv */
// output register: holds the buffer verdict until the receiver takes it
// depends on dclf_pkg
module dclf_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  dclf_pkg::result_t res,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              blocked
);

	logic valid_q;
	logic blocked_q;

	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res.push;
		end
	end

	always_ff @(posedge clk) begin
		if (res.push)
			blocked_q <= res.blocked;
	end

	assign out_valid = valid_q;
	assign blocked   = blocked_q;

endmodule

/* hdl/debugger_command_line_filter_core.sv */
// command line filter: splits a byte stream into lines and flags shell-escape commands
// top level; depends on dclf_pkg, dclf_in_reg, dclf_engine, dclf_out_reg
//
// usage
//   in_valid/in_ready carries data_byte and last_byte, one byte per transfer; a buffer
//   is any run of bytes closed by a byte with last_byte set.
//   out_valid/out_ready carries blocked, one transfer per buffer, issued for its last
//   byte: 1 when some line would run code and the bypass register is clear.
//   cfg_we/cfg_wdata write the bypass register; write it only while no
//   buffer is in flight.
// throughput and path
//   one byte per cycle sustained, but a last byte waits in the input register while
//   the output register holds an untaken verdict. the line state update lies between
//   the input register and the output register, which shows the verdict on out_valid.
// reset
//   arst_n clears the line state, the buffer flag and the bypass register and
//   empties both register stages.
// stall
//   while a verdict waits, bytes without last_byte still flow; a further last byte
//   waits in the input register and in_ready drops until out_ready frees the output.
module debugger_command_line_filter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       blocked
);

	dclf_pkg::byte_stage_t stage_s1;
	dclf_pkg::result_t     res;
	logic                  out_free;
	logic                  step;
	logic                  bypass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
		end else if (cfg_we) begin
			bypass_q <= cfg_wdata;
		end
	end

	// a last byte only moves on when the output register can take its verdict
	assign step = stage_s1.valid && (!stage_s1.last || out_free);

	dclf_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.step      (step),
		.stage_s1  (stage_s1)
	);

	dclf_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.stage_s1 (stage_s1),
		.bypass   (bypass_q),
		.res      (res)
	);

	dclf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.blocked   (blocked)
	);

endmodule

/* hdl/dclf_checker.sv */
// port-level checks for the command line filter, bound to the top level
// depends only on the ports of debugger_command_line_filter_core
module dclf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       last_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic       blocked
);

	// out_valid rises only after a last byte transfer has passed the input register into the output register
	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && last_byte, 2))
		else $error("verdict without a last byte two cycles earlier");

	// with the output register empty the input side never stalls
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(blocked))
		else $error("stalled verdict dropped or changed");

endmodule

bind debugger_command_line_filter_core dclf_checker u_dclf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last_byte (last_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.blocked   (blocked)
);

/* test/dclf_verdict_check.sv */
`timescale 1ns / 1ps
// line filter checker: follows both channel transfers and the bypass writes,
// predicts each buffer verdict and compares it with what the block gives
// depends on dclf_pkg for the line phase encoding
module dclf_verdict_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       blocked,
	output int         errors,
	output int         pending,
	output int         verdicts,
	output int         flagged
);

	localparam logic [7:0] NL   = 8'h0A;
	localparam logic [7:0] TAB  = 8'h09;
	localparam logic [7:0] CR   = 8'h0D;
	localparam logic [7:0] SP   = 8'h20;
	localparam logic [7:0] BANG = 8'h21;
	localparam logic [7:0] BAR  = 8'h7C;

	string interp_tag = "-interpreter-exec";

	// predicted line and buffer state
	dclf_pkg::phase_t ph;
	logic [4:0] names_live;
	logic [4:0] word_len;
	logic       tag_live;
	logic [7:0] scan_hist [5];
	logic [2:0] scan_seen;
	logic       buf_flagged;
	logic       bypass;

	logic verdict_q [$];

	function automatic string name_of(input int d);
		case (d)
			0: return "shell";
			1: return "pipe";
			2: return "python";
			3: return "guile";
			default: return "make";
		endcase
	endfunction

	task automatic clear_line();
		ph = dclf_pkg::PH_DIGIT;
		names_live = 5'h1F;
		word_len = '0;
		tag_live = 1'b1;
		scan_seen = '0;
		for (int i = 0; i < 5; i++) scan_hist[i] = '0;
	endtask

	task automatic close_word();
		if (word_len >= 2 && names_live != 0)
			buf_flagged = 1'b1;
		ph = dclf_pkg::PH_REST;
	endtask

	task automatic take_word_byte(input logic [7:0] b);
		string nm;
		if (b == SP || b == TAB || b == CR) begin
			close_word();
		end else begin
			for (int d = 0; d < 5; d++) begin
				nm = name_of(d);
				if (word_len < nm.len() && b != nm[word_len])
					names_live[d] = 1'b0;
			end
			if (word_len < 17 && b != interp_tag[word_len])
				tag_live = 1'b0;
			if (word_len < 31)
				word_len = word_len + 5'd1;
			// full tag seen: everything after it on this line gets scanned
			if (tag_live && word_len == 17) begin
				ph = dclf_pkg::PH_SCAN;
				scan_seen = '0;
				for (int i = 0; i < 5; i++) scan_hist[i] = '0;
			end
		end
	endtask

	task automatic take_scan_byte(input logic [7:0] b);
		string nm;
		int n;
		logic m;
		if (b == BANG || b == BAR)
			buf_flagged = 1'b1;
		for (int d = 0; d < 5; d++) begin
			nm = name_of(d);
			n = nm.len();
			// a name counts only if all of it lies inside the scan region
			if (scan_seen >= n - 1) begin
				m = (b == nm[n-1]);
				for (int i = 0; i < n - 1 && i < 5; i++)
					if (scan_hist[i] != nm[n-2-i])
						m = 1'b0;
				if (m)
					buf_flagged = 1'b1;
			end
		end
		for (int i = 4; i > 0; i--) scan_hist[i] = scan_hist[i-1];
		scan_hist[0] = b;
		if (scan_seen < 7)
			scan_seen = scan_seen + 3'd1;
	endtask

	task automatic filter_byte(input logic [7:0] b, input logic fin,
			output logic has_verdict, output logic verdict);
		logic digit_run;
		digit_run = 1'b0;
		has_verdict = 1'b0;
		verdict = 1'b0;
		if (b != NL) begin
			if (ph == dclf_pkg::PH_DIGIT) begin
				if (b >= 8'h30 && b <= 8'h39)
					digit_run = 1'b1;
				else
					ph = dclf_pkg::PH_SPACE;
			end
			if (!digit_run) begin
				case (ph)
					dclf_pkg::PH_SPACE: begin
						if (b == BANG || b == BAR) begin
							buf_flagged = 1'b1;
							ph = dclf_pkg::PH_REST;
						end else if (b != SP && b != TAB) begin
							ph = dclf_pkg::PH_WORD;
							take_word_byte(b);
						end
					end
					dclf_pkg::PH_WORD: take_word_byte(b);
					dclf_pkg::PH_SCAN: take_scan_byte(b);
					default: ;
				endcase
			end
		end
		if (b == NL || fin) begin
			if (ph == dclf_pkg::PH_WORD)
				close_word();
			clear_line();
		end
		if (fin) begin
			has_verdict = 1'b1;
			verdict = buf_flagged && !bypass;
			buf_flagged = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic has_v, exp_v, got_exp;
		if (!arst_n) begin
			clear_line();
			buf_flagged = 1'b0;
			bypass = 1'b0;
			verdict_q.delete();
			pending = 0;
			errors = 0;
			verdicts = 0;
			flagged = 0;
		end else begin
			if (out_valid && out_ready) begin
				verdicts = verdicts + 1;
				if (blocked === 1'b1)
					flagged = flagged + 1;
				if (verdict_q.size() == 0) begin
					$display("%0t: verdict transfer with none expected, got blocked=%b",
						$time, blocked);
					errors = errors + 1;
				end else begin
					got_exp = verdict_q.pop_front();
					if (blocked !== got_exp) begin
						$display("%0t: blocked mismatch, expected %b, got %b",
							$time, got_exp, blocked);
						errors = errors + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				filter_byte(data_byte, last_byte, has_v, exp_v);
				if (has_v)
					verdict_q.push_back(exp_v);
			end
			if (cfg_we)
				bypass = cfg_wdata;
			pending = verdict_q.size();
		end
	end

endmodule

/* test/debugger_command_line_filter_core_test.sv */
`timescale 1ns / 1ps
// testbench top for the command line filter: builds command buffers line by line,
// drives them with random gaps and output stalls, and reports the verdict
// depends on debugger_command_line_filter_core and dclf_verdict_check
module debugger_command_line_filter_core_test;

	localparam int RANDOM_BYTES = 950;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 300;

	localparam logic [7:0] NL  = 8'h0A;
	localparam logic [7:0] TAB = 8'h09;
	localparam logic [7:0] CR  = 8'h0D;
	localparam logic [7:0] SP  = 8'h20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_ready = 1'b0;
	wire        in_ready;
	wire        out_valid;
	wire        blocked;

	int errors, pending, verdicts, flagged;
	int cycles = 0;
	int sent = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	bit src_idle = 1'b1;
	bit sink_idle = 1'b1;

	logic [7:0] cmd_bytes [$];

	always #5 clk = ~clk;

	debugger_command_line_filter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.blocked   (blocked)
	);

	dclf_verdict_check judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.blocked   (blocked),
		.errors    (errors),
		.pending   (pending),
		.verdicts  (verdicts),
		.flagged   (flagged)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold counted here
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= !(sink_idle && $urandom_range(0, 99) < 15);
		end
	end

	function automatic string name_of(input int d);
		case (d)
			0: return "shell";
			1: return "pipe";
			2: return "python";
			3: return "guile";
			default: return "make";
		endcase
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) cmd_bytes.push_back(s[i]);
	endtask

	// one transfer; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (src_idle && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_buffer();
		for (int i = 0; i < cmd_bytes.size(); i++)
			send_byte(cmd_bytes[i], i == cmd_bytes.size() - 1);
		cmd_bytes.delete();
	endtask

	task automatic write_bypass(input logic v);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		// bytes with no verdict may still be in the pipe
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic gen_scan_tail();
		string nm;
		repeat ($urandom_range(0, 4)) begin
			nm = name_of($urandom_range(0, 4));
			case ($urandom_range(0, 9))
				0: push_str($urandom_range(0, 1) ? "!" : "|");
				1, 2, 3, 4: push_str(nm);
				5, 6: push_str(nm.substr(0, nm.len() - 2));
				7: cmd_bytes.push_back(SP);
				default: cmd_bytes.push_back(rand_letter());
			endcase
		end
	endtask

	task automatic gen_line();
		string nm;
		int n;
		int base;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				cmd_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 2)) cmd_bytes.push_back($urandom_range(0, 1) ? SP : TAB);
		base = cmd_bytes.size();
		case ($urandom_range(0, 11))
			0: push_str($urandom_range(0, 1) ? "!" : "|");
			1, 2, 3, 4, 5: begin
				// name prefix, whole name, or name with extra letters, now and then with one letter replaced
				nm = name_of($urandom_range(0, 4));
				n = $urandom_range(1, nm.len() + 2);
				for (int i = 0; i < n; i++)
					cmd_bytes.push_back(i < nm.len() ? nm[i] : rand_letter());
				if ($urandom_range(0, 5) == 0)
					cmd_bytes[base + $urandom_range(0, n - 1)] = rand_letter();
			end
			6, 7, 8: begin
				push_str("-interpreter-exec");
				if ($urandom_range(0, 7) == 0)
					cmd_bytes[base + $urandom_range(0, 16)] = rand_letter();
				gen_scan_tail();
			end
			9: cmd_bytes.push_back(CR);
			10: begin
				// mostly short plain words, now and then a long one that can run past the length cap
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
				repeat (n) cmd_bytes.push_back(rand_letter());
			end
			default: repeat ($urandom_range(1, 4)) cmd_bytes.push_back(8'($urandom_range(0, 255)));
		endcase
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 2))
				0: cmd_bytes.push_back(SP);
				1: cmd_bytes.push_back(TAB);
				default: cmd_bytes.push_back(CR);
			endcase
			repeat ($urandom_range(0, 3)) cmd_bytes.push_back(rand_letter());
			if ($urandom_range(0, 5) == 0)
				push_str(name_of($urandom_range(0, 4)));
		end
	endtask

	task automatic gen_buffer();
		int lines;
		lines = $urandom_range(1, 3);
		for (int i = 0; i < lines; i++) begin
			gen_line();
			if (i < lines - 1 || $urandom_range(0, 5) == 0)
				cmd_bytes.push_back(NL);
		end
	endtask

	initial begin
		int rand_base;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_bypass(1'b0);

		// directed: byte extremes, digit and blank skip, short name prefix,
		// empty line, tag followed by a bar, zero-length word, bar with bypass set
		cmd_bytes.push_back(8'h00);
		send_buffer();
		cmd_bytes.push_back(8'hFF);
		send_buffer();
		push_str("7\t!");
		send_buffer();
		push_str("sh\r");
		send_buffer();
		push_str("\n");
		send_buffer();
		push_str("-interpreter-exec|");
		send_buffer();
		push_str("\rma");
		send_buffer();
		write_bypass(1'b1);
		push_str("|");
		send_buffer();
		write_bypass(1'b0);

		rand_base = sent;
		while (sent - rand_base < RANDOM_BYTES) begin
			if (sent - rand_base >= 250 && sent - rand_base < 400 && cfg_wdata == 1'b0)
				write_bypass(1'b1);
			else if (sent - rand_base >= 400 && cfg_wdata == 1'b1)
				write_bypass(1'b0);
			// a stretch with no gaps on either side
			src_idle = !(sent - rand_base >= 500 && sent - rand_base < 700);
			sink_idle = src_idle;
			if (!hold_req && sent - rand_base >= 750)
				hold_req = 1'b1;
			gen_buffer();
			send_buffer();
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("covered %0d bytes in line buffers, %0d verdicts checked, %0d blocked",
			sent, verdicts, flagged);
		$display("bypass toggled both ways, gap-free stretch and one %0d-cycle output hold",
			HOLD_CYCLES);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
